// ===== hw/rtl/rde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_pkg
// Shared constants for the radix digit emitter.
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam int VALUE_BITS  = 32;  // width of the signed input value
  localparam int MAX_SYMBOLS = 64;  // largest alphabet the sweep will scan
  localparam int WORD_COUNT  = 8;   // symbol configuration words
  localparam int CFG_W       = 64;  // width of one symbol word
  localparam int CHAR_W      = 8;   // one symbol byte

  localparam int CFG_IDX_W  = $clog2(WORD_COUNT);
  localparam int SYM_ADDR_W = $clog2(WORD_COUNT * (CFG_W / CHAR_W));
  localparam int DIGIT_W    = SYM_ADDR_W;
  localparam int BASE_W     = $clog2(MAX_SYMBOLS + 1);
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int NDIG_W     = $clog2(VALUE_BITS + 1);

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_END   = 8'h00;

endpackage

// ===== hw/rtl/radix_digit_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_emitter
// Prints a signed value as text in a base set by a configurable alphabet.
// ----------------------------------------------------------------------------
// Each accepted value word produces its text one character word at a time,
// most significant digit first, with a leading '-' for negative values and
// last set on the final character. The alphabet lives in eight 64-bit symbol
// words, one byte per symbol; the base is the count of bytes before the first
// zero byte (64 if none). An alphabet with fewer than two symbols, a repeated
// symbol, '+' or '-' is invalid, and a value taken under it produces no
// output. The block handles one value at a time. After any configuration
// write, the first value runs an alphabet check that reads one symbol per
// cycle up to the first zero byte (at most 64 symbols); the result is
// kept until the next write. Digits come from a bit-serial restoring
// divider that retires one quotient bit per cycle and steps through every
// bit of the value for each digit; all digits are found before the first
// character is emitted, and characters then leave one per cycle while the
// output side keeps up. Configuration may only be written while the block
// is idle.
// ----------------------------------------------------------------------------
module radix_digit_emitter
  import rde_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  // configuration write port
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data,
  // value channel
  input  logic                        value_valid,
  output logic                        value_stall,
  input  logic signed [VALUE_BITS-1:0] value,
  // character channel
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [CHAR_W-1:0]           character,
  output logic                        last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t state;

  // symbol words as written through the configuration port
  logic [CFG_W-1:0] symbols [WORD_COUNT];

  // alphabet check results, kept until the next configuration write
  logic                  dirty;
  logic                  alph_ok;
  logic [BASE_W-1:0]     base;

  // alphabet sweep
  logic [SYM_ADDR_W-1:0] idx;
  logic                  bad;
  logic [255:0]          seen;

  // divider and digit stack
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic [DIGIT_W-1:0]    rem;
  logic [BIT_CNT_W-1:0]  bitcnt;
  logic                  qnz;
  logic [DIGIT_W-1:0]    digits [VALUE_BITS];
  logic [NDIG_W-1:0]     ndig;

  // single symbol read port shared by the sweep and the emitter
  logic [SYM_ADDR_W-1:0] rd_addr;
  logic [CHAR_W-1:0]     sym_rd;

  logic [VALUE_BITS-1:0] value_mag;
  logic [BASE_W-1:0]     trial;
  logic [BASE_W-1:0]     diff;
  logic                  ge;
  logic [DIGIT_W-1:0]    rem_new;
  logic                  sym_bad;
  logic                  end_hit;
  logic                  at_top;
  logic                  out_free;

  assign rd_addr = (state == ST_CHECK) ? idx : digits[0];
  assign sym_rd  = symbols[rd_addr[SYM_ADDR_W-1:3]][{rd_addr[2:0], 3'b000} +: CHAR_W];

  // magnitude at full width: the most negative value maps to 2^(n-1) unsigned
  assign value_mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;

  // one restoring-division step: bring in the next dividend bit
  assign trial   = {rem, mag[VALUE_BITS-1]};
  assign ge      = (trial >= base);
  assign diff    = trial - base;
  assign rem_new = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];

  // alphabet sweep decode for the symbol under the index
  assign end_hit = (sym_rd == CH_END);
  assign at_top  = (idx == SYM_ADDR_W'(MAX_SYMBOLS - 1));
  assign sym_bad = (sym_rd == CH_PLUS) || (sym_rd == CH_MINUS) || seen[sym_rd];

  assign out_free    = !result_valid || !result_stall;
  assign value_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      dirty        <= 1'b1;
      alph_ok      <= 1'b0;
      base         <= '0;
      result_valid <= 1'b0;
      ndig         <= '0;
      neg          <= 1'b0;
      for (int w = 0; w < WORD_COUNT; w++) begin
        symbols[w] <= '0;
      end
    end else begin
      if (cfg_write) begin
        symbols[cfg_index] <= cfg_data;
        dirty              <= 1'b1;
      end

      // drop the word once the consumer takes it; while emitting, the
      // emitter loads the next word itself
      if (result_valid && !result_stall && (state != ST_EMIT)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (value_valid) begin
            neg    <= value[VALUE_BITS-1];
            mag    <= value_mag;
            seen   <= '0;
            idx    <= '0;
            bad    <= 1'b0;
            ndig   <= '0;
            rem    <= '0;
            bitcnt <= '0;
            qnz    <= 1'b0;
            if (dirty) begin
              state <= ST_CHECK;
            end else if (alph_ok) begin
              state <= ST_DIVIDE;
            end
          end
        end

        ST_CHECK: begin
          if (end_hit) begin
            // alphabet ends here; length is the current index
            base    <= BASE_W'(idx);
            alph_ok <= !bad && (idx >= SYM_ADDR_W'(2));
            dirty   <= 1'b0;
            state   <= (!bad && (idx >= SYM_ADDR_W'(2))) ? ST_DIVIDE : ST_IDLE;
          end else begin
            seen[sym_rd] <= 1'b1;
            bad          <= bad | sym_bad;
            if (at_top) begin
              base    <= BASE_W'(MAX_SYMBOLS);
              alph_ok <= !(bad | sym_bad);
              dirty   <= 1'b0;
              state   <= (bad | sym_bad) ? ST_IDLE : ST_DIVIDE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end

        ST_DIVIDE: begin
          mag <= {mag[VALUE_BITS-2:0], ge};
          if (bitcnt == BIT_CNT_W'(VALUE_BITS - 1)) begin
            // remainder is the next digit; push it, low digits sink deeper
            digits[0] <= rem_new;
            for (int i = 1; i < VALUE_BITS; i++) begin
              digits[i] <= digits[i-1];
            end
            ndig   <= ndig + 1'b1;
            rem    <= '0;
            bitcnt <= '0;
            qnz    <= 1'b0;
            if (!(qnz || ge)) begin
              state <= ST_EMIT;
            end
          end else begin
            rem    <= rem_new;
            bitcnt <= bitcnt + 1'b1;
            qnz    <= qnz | ge;
          end
        end

        ST_EMIT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            if (neg) begin
              character <= CH_MINUS;
              last      <= 1'b0;
              neg       <= 1'b0;
            end else begin
              // top of stack is the most significant digit left
              character <= sym_rd;
              last      <= (ndig == NDIG_W'(1));
              for (int i = 0; i < VALUE_BITS - 1; i++) begin
                digits[i] <= digits[i+1];
              end
              ndig <= ndig - 1'b1;
              if (ndig == NDIG_W'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_divide_base_ok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (alph_ok && (base >= BASE_W'(2))))
    else $error("divider running without a valid base");

  a_rem_below_base: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (BASE_W'(rem) < base))
    else $error("partial remainder reached the base");

  a_stack_depth: assert property (@(posedge clk) disable iff (rst)
    ndig <= NDIG_W'(VALUE_BITS))
    else $error("digit stack overflow");

  a_emit_has_digit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (ndig != '0))
    else $error("emitting with an empty digit stack");

  a_last_ends_text: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && last) |=> !result_valid)
    else $error("character word follows the last one too soon");

endmodule
